// File: rtl/fsb_pkg.sv
`default_nettype none

package fsb_pkg;

  // Default frame size.
  localparam int unsigned FRAME_WIDTH_DEF  = 256;
  localparam int unsigned FRAME_HEIGHT_DEF = 256;

  // Command codes.
  localparam logic [1:0] CMD_RECT   = 2'd0;
  localparam logic [1:0] CMD_CIRCLE = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  // Coordinate math width: a 12-bit signed position plus a 12-bit size.
  localparam int CW    = 14;
  // Squared distance per axis, up to 4096 squared.
  localparam int SQW   = 25;
  // Squared radius.
  localparam int R2W   = 22;
  // Pixel counter width.
  localparam int CNT_W = 17;

  localparam logic [CNT_W-1:0] COUNT_MAX    = '1;
  localparam logic [8:0]       ALPHA_OPAQUE = 9'd256;

  // One command beat.
  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic [11:0]        rect_width;
    logic [11:0]        rect_height;
    logic [10:0]        radius;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [8:0]         alpha;
  } fsb_cmd_t;

  // One result beat.
  typedef struct packed {
    logic [23:0]      pixel_value;
    logic             status;
    logic [CNT_W-1:0] pixels_written;
  } fsb_res_t;

  // Source color with alpha already saturated to the opaque value.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] alpha;
  } fsb_src_t;

  // Frame store access request: read an entry, and blend it back next cycle.
  typedef struct packed {
    logic rd;
    logic wb;
  } fsb_acc_t;

  // Rounded blend of one channel: (dest*(256-a) + src*a + 128) >> 8.
  function automatic logic [7:0] blend_ch(input logic [7:0] dest, input logic [7:0] src,
                                          input logic [8:0] a);
    logic [16:0] sum;
    sum = 17'(dest) * 17'(ALPHA_OPAQUE - a) + 17'(src) * 17'(a) + 17'd128;
    return sum[15:8];
  endfunction

endpackage

`default_nettype wire

// File: rtl/fsb_frame_store.sv
`default_nettype none

module fsb_frame_store #(
  parameter int unsigned FRAME_WIDTH  = fsb_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = fsb_pkg::FRAME_HEIGHT_DEF,
  localparam int unsigned DEPTH = FRAME_WIDTH * FRAME_HEIGHT,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fsb_pkg::fsb_acc_t acc_i,
  input  logic [AW-1:0]     addr_i,
  input  fsb_pkg::fsb_src_t src_i,
  output logic [23:0]       rd_data_o,
  output logic              ready_o
);
  import fsb_pkg::*;

  logic [23:0]   mem [DEPTH];
  logic [23:0]   rd_q;
  logic          clr_busy_q;
  logic [AW-1:0] clr_idx_q;
  logic          wb_q;
  logic [AW-1:0] wb_addr_q;

  logic          we;
  logic [AW-1:0] wa;
  logic [23:0]   wd;
  logic [23:0]   blended;

  // Blend the entry read last cycle with the source color.
  assign blended = {blend_ch(rd_q[23:16], src_i.red, src_i.alpha),
                    blend_ch(rd_q[15:8], src_i.green, src_i.alpha),
                    blend_ch(rd_q[7:0], src_i.blue, src_i.alpha)};

  // The clearing pass owns the write port until it has swept every entry.
  assign we = clr_busy_q | wb_q;
  assign wa = clr_busy_q ? clr_idx_q : wb_addr_q;
  assign wd = clr_busy_q ? 24'd0 : blended;

  // Memory array: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (acc_i.rd) begin
      rd_q <= mem[addr_i];
    end
  end

  // Clearing sweep and write-back tracking.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
      wb_q       <= 1'b0;
    end else begin
      wb_q <= acc_i.wb & ~clr_busy_q;
      if (clr_busy_q) begin
        if (clr_idx_q == AW'(DEPTH - 1)) begin
          clr_busy_q <= 1'b0;
        end else begin
          clr_idx_q <= clr_idx_q + AW'(1);
        end
      end
    end
  end

  // The write-back address is the read address, registered.
  always_ff @(posedge clk_i) begin
    wb_addr_q <= addr_i;
  end

  assign rd_data_o = rd_q;
  assign ready_o   = ~clr_busy_q;

endmodule

`default_nettype wire

// File: rtl/fsb_walker.sv
`default_nettype none

module fsb_walker #(
  parameter int unsigned FRAME_WIDTH  = fsb_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = fsb_pkg::FRAME_HEIGHT_DEF,
  localparam int unsigned DEPTH = FRAME_WIDTH * FRAME_HEIGHT,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         go_i,
  input  fsb_pkg::fsb_cmd_t            cmd_i,
  output fsb_pkg::fsb_acc_t            acc_o,
  output logic [AW-1:0]                addr_o,
  output logic                         done_o,
  output logic [fsb_pkg::CNT_W-1:0]    count_o
);
  import fsb_pkg::*;

  localparam int unsigned XW = $clog2(FRAME_WIDTH + 1);
  localparam int unsigned YW = $clog2(FRAME_HEIGHT + 1);
  localparam int          DW = SQW + 1;

  typedef enum logic [2:0] {W_IDLE, W_BOUNDS, W_DX, W_DY, W_BASE, W_RUN} walk_state_e;

  walk_state_e           state_q;
  logic                  is_rect_q;
  logic signed [CW-1:0]  cx_q, cy_q;
  logic [11:0]           w_q, h_q;
  logic [10:0]           rad_q;
  logic [XW-1:0]         x0_q, x1_q, x_q;
  logic [YW-1:0]         y0_q, y1_q, y_q;
  logic [R2W-1:0]        r2_q;
  logic signed [CW-1:0]  dx0_q, dx_q, dy_q;
  logic [SQW-1:0]        dx0sq_q, dxsq_q, dysq_q;
  logic [AW-1:0]         row_base_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  done_q;

  logic signed [CW-1:0]   lo_x, hi_x, lo_y, hi_y;
  logic signed [CW-1:0]   dx0, dy0;
  logic signed [2*CW-1:0] dx0_prod, dy0_prod;
  logic [SQW-1:0]         dx_step, dy_step;
  logic                   covered, last_x, last_y, empty;

  // Clamp one box edge into [0, lim].
  function automatic logic [CW-1:0] clamp_edge(input logic signed [CW-1:0] v,
                                               input logic [CW-1:0] lim);
    logic [CW-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed(lim)) begin
      res = lim;
    end else begin
      res = CW'(v);
    end
    return res;
  endfunction

  // Box edges before clamping: a rectangle spans its size, a circle its radius.
  assign lo_x = is_rect_q ? cx_q : cx_q - CW'(rad_q);
  assign hi_x = is_rect_q ? cx_q + CW'(w_q) : cx_q + CW'(rad_q);
  assign lo_y = is_rect_q ? cy_q : cy_q - CW'(rad_q);
  assign hi_y = is_rect_q ? cy_q + CW'(h_q) : cy_q + CW'(rad_q);

  // Offsets of the first pixel corner from the center and their squares.
  assign dx0      = $signed(CW'(x0_q)) - cx_q;
  assign dy0      = $signed(CW'(y0_q)) - cy_q;
  assign dx0_prod = dx0 * dx0;
  assign dy0_prod = dy0 * dy0;

  // Next square from (d+1)^2 = d^2 + 2d + 1.
  assign dx_step = dxsq_q + SQW'(signed'({dx_q, 1'b1}));
  assign dy_step = dysq_q + SQW'(signed'({dy_q, 1'b1}));

  assign covered = is_rect_q || (({1'b0, dxsq_q} + {1'b0, dysq_q}) <= DW'(r2_q));
  assign last_x  = (x_q == x1_q - XW'(1));
  assign last_y  = (y_q == y1_q - YW'(1));
  assign empty   = (x1_q <= x0_q) || (y1_q <= y0_q);

  // Walk sequencer: setup in the BOUNDS, DX, DY and BASE states, then one pixel per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        W_IDLE: begin
          if (go_i) begin
            is_rect_q <= (cmd_i.cmd == CMD_RECT);
            cx_q      <= CW'(cmd_i.pos_x);
            cy_q      <= CW'(cmd_i.pos_y);
            w_q       <= cmd_i.rect_width;
            h_q       <= cmd_i.rect_height;
            rad_q     <= cmd_i.radius;
            cnt_q     <= '0;
            state_q   <= W_BOUNDS;
          end
        end
        W_BOUNDS: begin
          x0_q    <= XW'(clamp_edge(lo_x, CW'(FRAME_WIDTH)));
          x1_q    <= XW'(clamp_edge(hi_x, CW'(FRAME_WIDTH)));
          y0_q    <= YW'(clamp_edge(lo_y, CW'(FRAME_HEIGHT)));
          y1_q    <= YW'(clamp_edge(hi_y, CW'(FRAME_HEIGHT)));
          r2_q    <= R2W'(rad_q) * R2W'(rad_q);
          state_q <= W_DX;
        end
        W_DX: begin
          if (empty) begin
            done_q  <= 1'b1;
            state_q <= W_IDLE;
          end else begin
            dx0_q   <= dx0;
            dx0sq_q <= dx0_prod[SQW-1:0];
            state_q <= W_DY;
          end
        end
        W_DY: begin
          dy_q    <= dy0;
          dysq_q  <= dy0_prod[SQW-1:0];
          state_q <= W_BASE;
        end
        W_BASE: begin
          row_base_q <= AW'(AW'(y0_q) * AW'(FRAME_WIDTH));
          x_q        <= x0_q;
          y_q        <= y0_q;
          dx_q       <= dx0_q;
          dxsq_q     <= dx0sq_q;
          state_q    <= W_RUN;
        end
        W_RUN: begin
          if (covered && (cnt_q != COUNT_MAX)) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
          if (last_x) begin
            x_q        <= x0_q;
            dx_q       <= dx0_q;
            dxsq_q     <= dx0sq_q;
            y_q        <= y_q + YW'(1);
            dy_q       <= dy_q + CW'(1);
            dysq_q     <= dy_step;
            row_base_q <= row_base_q + AW'(FRAME_WIDTH);
            if (last_y) begin
              done_q  <= 1'b1;
              state_q <= W_IDLE;
            end
          end else begin
            x_q    <= x_q + XW'(1);
            dx_q   <= dx_q + CW'(1);
            dxsq_q <= dx_step;
          end
        end
        default: begin
          state_q <= W_IDLE;
        end
      endcase
    end
  end

  // Each covered pixel is read and blended back by the frame store.
  assign acc_o.rd = (state_q == W_RUN) && covered;
  assign acc_o.wb = (state_q == W_RUN) && covered;
  assign addr_o   = row_base_q + AW'(x_q);
  assign done_o   = done_q;
  assign count_o  = cnt_q;

endmodule

`default_nettype wire

// File: rtl/shape_fill_blend_engine.sv
// Channel   Direction  Handshake           Payload
// command   in         start / busy        cmd_i  (fsb_cmd_t)
// result    out        done_o strobe       res_o  (fsb_res_t)
//
// A command is taken when start is high and busy is low; one result beat follows.
// A fill result follows the walker's setup states and its walk over every pixel of the
// clipped box; an empty box ends the walk at the DX state. A read passes through the
// RADDR and RDATA states, and the unused code returns its result straight from idle.
// After reset busy stays high while the store is cleared to black, one entry per cycle.
// The result is shown on done_o for one cycle; the receiver cannot stall it.
`default_nettype none

module shape_fill_blend_engine #(
  parameter int unsigned FRAME_WIDTH  = fsb_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = fsb_pkg::FRAME_HEIGHT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  fsb_pkg::fsb_cmd_t cmd_i,
  output logic              busy,
  output logic              done_o,
  output fsb_pkg::fsb_res_t res_o
);
  import fsb_pkg::*;

  localparam int unsigned DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned XW    = $clog2(FRAME_WIDTH + 1);
  localparam int unsigned YW    = $clog2(FRAME_HEIGHT + 1);

  typedef enum logic [1:0] {S_IDLE, S_DRAW, S_RADDR, S_RDATA} top_state_e;

  top_state_e       state_q;
  fsb_src_t         src_q;
  logic             rd_ok_q;
  logic [XW-1:0]    rd_x_q;
  logic [YW-1:0]    rd_y_q;
  logic             done_q;
  fsb_res_t         res_q;

  logic             accept, is_draw, in_frame, store_ready, walk_done;
  fsb_acc_t         walk_acc, store_acc;
  logic [AW-1:0]    walk_addr, rd_addr, store_addr;
  logic [23:0]      rd_data;
  logic [CNT_W-1:0] walk_count;

  assign busy    = ~store_ready | (state_q != S_IDLE);
  assign accept  = start & ~busy;
  assign is_draw = (cmd_i.cmd == CMD_RECT) || (cmd_i.cmd == CMD_CIRCLE);

  // A read position is inside the frame when both coordinates are in range.
  assign in_frame = !cmd_i.pos_x[11] && ({1'b0, cmd_i.pos_x} < 13'(FRAME_WIDTH)) &&
                    !cmd_i.pos_y[11] && ({1'b0, cmd_i.pos_y} < 13'(FRAME_HEIGHT));

  assign rd_addr = AW'(AW'(rd_y_q) * AW'(FRAME_WIDTH) + AW'(rd_x_q));

  // The read command borrows the store port; otherwise the walker owns it.
  always_comb begin
    store_acc  = walk_acc;
    store_addr = walk_addr;
    if (state_q == S_RADDR) begin
      store_acc.rd = rd_ok_q;
      store_acc.wb = 1'b0;
      store_addr   = rd_addr;
    end
  end

  // Command sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            src_q.red   <= cmd_i.red;
            src_q.green <= cmd_i.green;
            src_q.blue  <= cmd_i.blue;
            src_q.alpha <= (cmd_i.alpha > ALPHA_OPAQUE) ? ALPHA_OPAQUE : cmd_i.alpha;
            rd_ok_q     <= in_frame;
            rd_x_q      <= XW'(cmd_i.pos_x);
            rd_y_q      <= YW'(cmd_i.pos_y);
            if (is_draw) begin
              state_q <= S_DRAW;
            end else if (cmd_i.cmd == CMD_READ) begin
              state_q <= S_RADDR;
            end else begin
              done_q <= 1'b1;
              res_q  <= '0;
            end
          end
        end
        S_DRAW: begin
          if (walk_done) begin
            done_q               <= 1'b1;
            res_q.pixel_value    <= '0;
            res_q.status         <= 1'b0;
            res_q.pixels_written <= walk_count;
            state_q              <= S_IDLE;
          end
        end
        S_RADDR: begin
          state_q <= S_RDATA;
        end
        S_RDATA: begin
          done_q               <= 1'b1;
          res_q.pixel_value    <= rd_ok_q ? rd_data : 24'd0;
          res_q.status         <= ~rd_ok_q;
          res_q.pixels_written <= '0;
          state_q              <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  fsb_walker #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (accept & is_draw),
    .cmd_i  (cmd_i),
    .acc_o  (walk_acc),
    .addr_o (walk_addr),
    .done_o (walk_done),
    .count_o(walk_count)
  );

  fsb_frame_store #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (store_acc),
    .addr_i   (store_addr),
    .src_i    (src_q),
    .rd_data_o(rd_data),
    .ready_o  (store_ready)
  );

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

// File: rtl/fsb_checker.sv
`default_nettype none

module fsb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input logic              busy_i,
  input fsb_pkg::fsb_cmd_t cmd_i,
  input logic              done_i,
  input fsb_pkg::fsb_res_t res_i
);
  import fsb_pkg::*;

  // A taken draw or read command keeps the engine busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i && (cmd_i.cmd != CMD_NOP) |=> busy_i)
    else $error("engine not busy after a command beat");

  // The engine is free again when its result shows.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> !busy_i)
    else $error("result beat while busy");

  // A read outside the frame returns nothing but the status flag.
  a_read_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && res_i.status |-> (res_i.pixel_value == '0) && (res_i.pixels_written == '0))
    else $error("out of frame read carries data");

  // A draw result carries only its pixel count.
  a_draw_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && (res_i.pixels_written != '0) |-> (res_i.pixel_value == '0) && !res_i.status)
    else $error("draw result carries read data");

endmodule

bind shape_fill_blend_engine fsb_checker u_fsb_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start_i(start),
  .busy_i (busy),
  .cmd_i  (cmd_i),
  .done_i (done_o),
  .res_i  (res_o)
);

`default_nettype wire

// File: tb/sv/tb_shape_fill_blend_engine.sv
`timescale 1ns / 100ps

module tb_shape_fill_blend_engine;
  import fsb_pkg::*;

  localparam int FW = FRAME_WIDTH_DEF;
  localparam int FH = FRAME_HEIGHT_DEF;
  localparam int RANDOM_BEATS = 75;
  localparam int SETTLE_CYCLES = 100;
  localparam int REPORT_LIMIT = 10;
  localparam int CMD_BITS = $bits(fsb_cmd_t);

  // One queued command beat, the idle cycles in front of it, and whether the
  // sender must first wait for every outstanding result.
  typedef struct {
    fsb_cmd_t beat;
    int       gap;
    bit       drain;
  } pending_cmd_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  fsb_cmd_t cmd_i = '0;
  logic     busy;
  logic     done_o;
  fsb_res_t res_o;

  // Shadow copy of the frame store, lowest row index first.
  logic [23:0]  canvas [0:FW*FH-1];
  pending_cmd_t cmd_q[$];
  fsb_res_t     result_q[$];
  int           n_sent = 0;
  int           n_taken = 0;
  int           gap_left = 0;
  int           n_errors = 0;

  shape_fill_blend_engine uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Rounded per-channel blend of source over destination.
  function automatic logic [7:0] mix_channel(input int dest, input int src, input int a);
    return 8'((dest * (256 - a) + src * a + 128) >> 8);
  endfunction

  function automatic void blend_pixel(input int x, input int y, input fsb_cmd_t c, input int a);
    logic [23:0] d;
    d = canvas[y*FW + x];
    canvas[y*FW + x] = {mix_channel(d[23:16], c.red, a), mix_channel(d[15:8], c.green, a),
                        mix_channel(d[7:0], c.blue, a)};
  endfunction

  function automatic int clamp_edge(input int v, input int limit);
    if (v < 0) return 0;
    if (v > limit) return limit;
    return v;
  endfunction

  // Applies one command to the shadow frame and returns the result it should produce.
  function automatic fsb_res_t fill_and_read(input fsb_cmd_t c);
    fsb_res_t r;
    int       px, py, w, h, rad, a, x0, x1, y0, y1, x, y, dx, dy, r2;
    longint   cnt;
    r = '0;
    cnt = 0;
    px = $signed(c.pos_x);
    py = $signed(c.pos_y);
    w = c.rect_width;
    h = c.rect_height;
    rad = c.radius;
    a = (c.alpha > ALPHA_OPAQUE) ? 256 : int'(c.alpha);
    case (c.cmd)
      CMD_RECT: begin
        // Negative corners eat into the size; far edges are cut at the frame.
        if (px < 0) begin
          w += px;
          px = 0;
        end
        if (py < 0) begin
          h += py;
          py = 0;
        end
        if (px + w >= FW) w = FW - px;
        if (py + h >= FH) h = FH - py;
        if (w > 0 && h > 0) begin
          for (y = py; y < py + h; y++) begin
            for (x = px; x < px + w; x++) begin
              blend_pixel(x, y, c, a);
              cnt++;
            end
          end
        end
      end
      CMD_CIRCLE: begin
        // Walk the clipped bounding box and test each pixel corner.
        x0 = clamp_edge(px - rad, FW);
        x1 = clamp_edge(px + rad, FW);
        y0 = clamp_edge(py - rad, FH);
        y1 = clamp_edge(py + rad, FH);
        r2 = rad * rad;
        for (y = y0; y < y1; y++) begin
          for (x = x0; x < x1; x++) begin
            dx = x - px;
            dy = y - py;
            if (dx * dx + dy * dy <= r2) begin
              blend_pixel(x, y, c, a);
              cnt++;
            end
          end
        end
      end
      CMD_READ: begin
        if (px < 0 || py < 0 || px >= FW || py >= FH) r.status = 1'b1;
        else r.pixel_value = canvas[py*FW + px];
      end
      default: begin
      end
    endcase
    r.pixels_written = (cnt > COUNT_MAX) ? COUNT_MAX : cnt[CNT_W-1:0];
    return r;
  endfunction

  function automatic fsb_cmd_t make_cmd(input logic [1:0] op, input int x, input int y,
                                        input int w, input int h, input int rad,
                                        input logic [23:0] rgb, input int a);
    fsb_cmd_t c;
    c.cmd = op;
    c.pos_x = 12'(x);
    c.pos_y = 12'(y);
    c.rect_width = 12'(w);
    c.rect_height = 12'(h);
    c.radius = 11'(rad);
    c.red = rgb[23:16];
    c.green = rgb[15:8];
    c.blue = rgb[7:0];
    c.alpha = 9'(a);
    return c;
  endfunction

  // Mostly back-to-back beats, some short pauses and a few long ones.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  task automatic queue_cmd(input fsb_cmd_t c, input int gap, input bit drain);
    pending_cmd_t p;
    p.beat = c;
    p.gap = gap;
    p.drain = drain;
    cmd_q.push_back(p);
  endtask

  // Random command: mostly small shapes and reads in and around the frame,
  // a little noise over all fields, and now and then a large shape.
  function automatic fsb_cmd_t random_cmd();
    fsb_cmd_t c;
    int       sel, ap;
    c = fsb_cmd_t'(CMD_BITS'({$urandom, $urandom, $urandom}));
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      c.cmd = CMD_READ;
      c.pos_x = 12'($urandom_range(0, 263) - 4);
      c.pos_y = 12'($urandom_range(0, 263) - 4);
    end else if (sel < 65) begin
      c.cmd = CMD_RECT;
      c.pos_x = 12'($urandom_range(0, 300) - 20);
      c.pos_y = 12'($urandom_range(0, 300) - 20);
      c.rect_width = 12'($urandom_range(0, 40));
      c.rect_height = 12'($urandom_range(0, 40));
    end else if (sel < 90) begin
      c.cmd = CMD_CIRCLE;
      c.pos_x = 12'($urandom_range(0, 300) - 20);
      c.pos_y = 12'($urandom_range(0, 300) - 20);
      c.radius = 11'($urandom_range(0, 24));
    end else begin
      // Noise: any code, any position, but kept cheap to draw.
      c.rect_height = 12'($urandom_range(0, 2));
      c.radius = 11'($urandom_range(0, 7));
    end
    if ($urandom_range(0, 29) == 0) begin
      c.pos_x = 12'($urandom_range(0, 300) - 20);
      c.pos_y = 12'($urandom_range(0, 300) - 20);
      c.rect_width = 12'($urandom);
      c.rect_height = 12'($urandom);
      c.radius = 11'($urandom);
    end
    ap = $urandom_range(0, 99);
    if (ap < 60) c.alpha = 9'($urandom_range(0, 256));
    else if (ap < 80) c.alpha = ALPHA_OPAQUE;
    return c;
  endfunction

  // Command driver: updates at the falling edge, holds a beat until it is taken.
  always @(negedge clk_i) begin
    logic         go;
    fsb_cmd_t     beat;
    pending_cmd_t head;
    go = start;
    beat = cmd_i;
    if (start && n_taken == n_sent) go = 1'b0;
    if (!go && rst_ni) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_q.size() > 0 && !(cmd_q[0].drain && result_q.size() > 0)) begin
        if (cmd_q[0].gap > 0) begin
          gap_left = cmd_q[0].gap - 1;
          cmd_q[0].gap = 0;
        end else begin
          head = cmd_q.pop_front();
          beat = head.beat;
          go = 1'b1;
          n_sent++;
        end
      end
    end
    start <= go;
    cmd_i <= beat;
  end

  // Result monitor and command capture at the rising edge. A result never
  // shares an edge with its own command, so results are checked first.
  always @(posedge clk_i) begin
    fsb_res_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (result_q.size() == 0) begin
          n_errors++;
          if (n_errors <= REPORT_LIMIT)
            $display("%0t: result beat with nothing outstanding: pixel %06h status %0d count %0d",
                     $realtime, res_o.pixel_value, res_o.status, res_o.pixels_written);
        end else begin
          want = result_q.pop_front();
          if (res_o.pixel_value !== want.pixel_value || res_o.status !== want.status ||
              res_o.pixels_written !== want.pixels_written) begin
            n_errors++;
            if (n_errors <= REPORT_LIMIT)
              $display("%0t: mismatch: pixel %06h/%06h status %0d/%0d count %0d/%0d (exp/got)",
                       $realtime, want.pixel_value, res_o.pixel_value, want.status,
                       res_o.status, want.pixels_written, res_o.pixels_written);
          end
        end
      end
      if (start && !busy) begin
        result_q.push_back(fill_and_read(cmd_i));
        n_taken++;
      end
    end
  end

  initial begin
    int i;
    for (i = 0; i < FW*FH; i++) canvas[i] = '0;

    // Directed beats: reads on a black frame, clipping corners, empty shapes,
    // alpha extremes, an unused command code, and read-back of drawn areas.
    queue_cmd(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 24'h0, 0), 0, 1'b0);
    queue_cmd(make_cmd(CMD_READ, -1, 5, 0, 0, 0, 24'h0, 0), 0, 1'b0);
    queue_cmd(make_cmd(CMD_READ, 256, 0, 0, 0, 0, 24'h0, 0), 1, 1'b0);
    queue_cmd(make_cmd(CMD_READ, 2047, -2048, 0, 0, 0, 24'h0, 0), 0, 1'b0);
    queue_cmd(make_cmd(CMD_RECT, 0, 0, 256, 256, 0, 24'h123456, 256), 0, 1'b1);
    queue_cmd(make_cmd(CMD_RECT, -2048, -5, 4095, 10, 0, 24'hFF0080, 300), 3, 1'b0);
    queue_cmd(make_cmd(CMD_RECT, 250, 250, 20, 20, 0, 24'h00FF00, 128), 0, 1'b0);
    queue_cmd(make_cmd(CMD_RECT, 10, 10, 0, 7, 0, 24'hABCDEF, 256), 0, 1'b0);
    queue_cmd(make_cmd(CMD_RECT, 300, 10, 5, 5, 0, 24'hABCDEF, 256), 0, 1'b0);
    queue_cmd(make_cmd(CMD_RECT, 7, 9, 1, 1, 0, 24'hFFFFFF, 0), 0, 1'b0);
    queue_cmd(make_cmd(CMD_RECT, 100, 100, 5, 5, 0, 24'hFFFFFF, 511), 0, 1'b0);
    queue_cmd(make_cmd(CMD_CIRCLE, 40, 40, 0, 0, 0, 24'h777777, 256), 0, 1'b0);
    queue_cmd(make_cmd(CMD_CIRCLE, 128, 128, 0, 0, 10, 24'h804020, 200), 2, 1'b0);
    queue_cmd(make_cmd(CMD_CIRCLE, 2, 3, 0, 0, 8, 24'h0A0B0C, 256), 0, 1'b0);
    queue_cmd(make_cmd(CMD_CIRCLE, 128, 128, 0, 0, 2047, 24'hFFFFFF, 64), 0, 1'b0);
    queue_cmd(make_cmd(CMD_CIRCLE, -2048, 2047, 0, 0, 2047, 24'h555555, 256), 0, 1'b1);
    queue_cmd(make_cmd(CMD_NOP, 5, 5, 4, 4, 3, 24'hC0FFEE, 256), 0, 1'b0);
    queue_cmd(make_cmd(CMD_READ, 128, 128, 0, 0, 0, 24'h0, 0), 0, 1'b0);
    queue_cmd(make_cmd(CMD_READ, 255, 255, 0, 0, 0, 24'h0, 0), 0, 1'b0);
    queue_cmd(make_cmd(CMD_READ, 252, 253, 0, 0, 0, 24'h0, 0), 5, 1'b0);
    queue_cmd(make_cmd(CMD_READ, 2, 3, 0, 0, 0, 24'h0, 0), 0, 1'b0);
    queue_cmd(make_cmd(CMD_READ, 100, 100, 0, 0, 0, 24'h0, 0), 0, 1'b0);
    queue_cmd(make_cmd(CMD_READ, 0, 255, 0, 0, 0, 24'h0, 0), 0, 1'b0);
    queue_cmd(make_cmd(CMD_READ, 255, 0, 0, 0, 0, 24'h0, 0), 0, 1'b0);
    queue_cmd(make_cmd(CMD_READ, 7, 9, 0, 0, 0, 24'h0, 0), 0, 1'b0);

    // Random beats; one stretch runs with no idle cycles at all.
    for (i = 0; i < RANDOM_BEATS; i++)
      queue_cmd(random_cmd(), (i >= 55 && i < 75) ? 0 : pick_gap(), i == 50);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_q.size() > 0 || start || result_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (n_errors == 0 && result_q.size() == 0)
      $display("tb_shape_fill_blend_engine: PASS");
    else
      $display("tb_shape_fill_blend_engine: FAIL");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #(64'd400_000_000);
    $display("tb_shape_fill_blend_engine: FAIL");
    $finish;
  end

endmodule
